@@ rtl/itad_pkg.sv @@
`timescale 1ns / 1ps

package itad_pkg;

  localparam int unsigned NUM_W     = 32;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W     = NUM_DIGITS * DIGIT_W;
  localparam int unsigned BIT_CNT_W = 5;
  localparam int unsigned LEFT_W    = 4;
  localparam int unsigned CHAR_W    = 7;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT      = 5'd31;
  localparam logic [LEFT_W-1:0]    ALL_DIGITS    = 4'd10;
  localparam logic [LEFT_W-1:0]    ONE_DIGIT     = 4'd1;
  localparam logic [DIGIT_W-1:0]   DABBLE_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0]   DABBLE_ADD    = 4'd3;
  localparam logic [DIGIT_W-1:0]   FIRST_LETTER  = 4'd10;
  localparam logic [CHAR_W-1:0]    CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]    CHAR_A_OFFSET = 7'h37;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic hex;
    logic step;
    logic shift;
  } dabble_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < FIRST_LETTER) begin
      return CHAR_ZERO + wide;
    end
    return CHAR_A_OFFSET + wide;
  endfunction

endpackage

@@ rtl/integer_to_ascii_digits_unit.sv @@
`timescale 1ns / 1ps

// Converts a 32-bit unsigned value to ASCII decimal or hexadecimal digits, most
// significant first, leading zeros dropped, the final digit flagged by
// out_last_digit. A transaction is taken when start is high and busy is low.
// Each digit appears for one cycle with out_valid; the receiver cannot stall, so
// it must take every strobe. Decimal runs a bit-serial shift-and-add-3 pass,
// then scans past leading zeros one digit a cycle, then emits one digit a
// cycle. Hexadecimal skips the shift-and-add-3 pass; both scan and emit from
// the ten-digit shift register.
module integer_to_ascii_digits_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [itad_pkg::NUM_W-1:0]        in_number,
  input  logic                              in_base_is_hex,
  output logic                              out_valid,
  output logic [itad_pkg::CHAR_W-1:0]       out_digit_char,
  output logic                              out_last_digit
);
  import itad_pkg::*;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r;
  logic [BIT_CNT_W-1:0]   bit_cnt_nxt;
  logic [LEFT_W-1:0]      left_r;
  logic [LEFT_W-1:0]      left_nxt;
  dabble_ctrl_t           ctrl;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  itad_dabble u_dabble (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_value (in_number),
    .top_digit  (top_digit)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_base_is_hex ? ST_SCAN : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == LAST_BIT) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (top_digit != '0 || left_r == ONE_DIGIT) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (left_r == ONE_DIGIT) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    out_valid      = 1'b0;
    out_last_digit = 1'b0;
    bit_cnt_nxt    = bit_cnt_r;
    left_nxt       = left_r;
    case (state_r)
      ST_IDLE: begin
        ctrl.load   = accept;
        ctrl.hex    = in_base_is_hex;
        bit_cnt_nxt = '0;
        left_nxt    = ALL_DIGITS;
      end
      ST_CONV: begin
        ctrl.step   = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      ST_SCAN: begin
        if (top_digit == '0 && left_r != ONE_DIGIT) begin
          ctrl.shift = 1'b1;
          left_nxt   = left_r - 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid      = 1'b1;
        out_last_digit = (left_r == ONE_DIGIT);
        ctrl.shift     = 1'b1;
        left_nxt       = left_r - 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  assign out_digit_char = digit_glyph(top_digit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bit_cnt_r <= bit_cnt_nxt;
    left_r    <= left_nxt;
  end

endmodule

@@ rtl/itad_dabble.sv @@
`timescale 1ns / 1ps

module itad_dabble (
  input  logic                                clk,
  input  itad_pkg::dabble_ctrl_t              ctrl,
  input  logic [itad_pkg::NUM_W-1:0]          load_value,
  output logic [itad_pkg::DIGIT_W-1:0]        top_digit
);
  import itad_pkg::*;

  logic [NUM_W-1:0] bin_r;
  logic [NUM_W-1:0] bin_nxt;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      bin_nxt = load_value;
      if (ctrl.hex) begin
        bcd_nxt = {{(BCD_W-NUM_W){1'b0}}, load_value};
      end else begin
        bcd_nxt = '0;
      end
    end else if (ctrl.step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
      bin_nxt = {bin_r[NUM_W-2:0], 1'b0};
    end else if (ctrl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule
